/* src/tlpm_pkg.sv */
// ----------------------------------------------------------------------------
// tlpm_pkg
// Shared types and constants for the two-level page map translator.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpm_pkg;

    // Address split: directory index, table index, page offset
    localparam int DIR_SHIFT     = 22;
    localparam int PAGE_SHIFT    = 12;
    localparam int IDX_W         = 10;
    localparam int OFFSET_W      = 12;
    localparam int DIR_SLOTS     = 1024;
    localparam int TABLE_ENTRIES = 1024;
    localparam logic [31:0] PRESENT_BIT = 32'h0000_0001;

    // Request kinds
    localparam logic KIND_TRANSLATE = 1'b0;
    localparam logic KIND_MAP       = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_DIR_ABSENT = 3'd1,
        STAT_PG_ABSENT  = 3'd2,
        STAT_ALREADY    = 3'd3,
        STAT_NO_TABLE   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR,
        S_ENT
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [31:0] virtual_address;
        logic [31:0] physical_address;
        logic [7:0]  flags;
    } t_req;

    typedef struct packed {
        logic [31:0] translated_address;
        t_status     status;
    } t_rsp;

    // Sequencer to datapath control
    typedef struct packed {
        logic ready;      // a request may be taken this cycle
        logic dir_stage;  // directory read data is valid
        logic finish;     // entry data valid and result register free
        logic clearing;   // post-reset sweep in progress
        logic clr_dir;    // sweep address also lies inside the directory
    } t_seq_ctrl;

endpackage

`default_nettype wire

/* src/two_level_page_map_translate.sv */
// ----------------------------------------------------------------------------
// two_level_page_map_translate
// Two-level page map: translate and map requests over a directory RAM and a
// page-table entry RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps both RAMs to zero, one entry a cycle, over the
// TABLE_POOL * 1024 entries (16384 by default); o_ready stays low until the
// sweep is done. Each request then passes a directory step (directory RAM
// read, and table allocation on a map) and an entry step (entry RAM read, and
// entry write on a map). A new request is taken in the previous one's entry
// step once the result register is free; the result is held there until taken.
// A map to an empty directory slot takes the next of TABLE_POOL tables.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_page_map_translate #(
    parameter int TABLE_POOL = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire tlpm_pkg::t_req   i_req,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output tlpm_pkg::t_rsp        o_rsp
);
    import tlpm_pkg::*;

    localparam int TW        = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
    localparam int UW        = $clog2(TABLE_POOL + 1);
    localparam int ENT_DEPTH = TABLE_POOL * TABLE_ENTRIES;
    localparam int EAW       = $clog2(ENT_DEPTH);
    localparam int DW        = TW + 1;

    t_seq_ctrl      ctrl;
    logic [EAW-1:0] clr_addr;
    logic           out_free;

    t_req           r_req;
    logic [UW-1:0]  r_used;
    logic [EAW-1:0] r_ent_addr;
    logic           r_dir_hit;
    logic           r_no_table;
    logic           r_out_valid;
    t_rsp           r_rsp, n_rsp;

    logic           dir_we;
    logic [IDX_W-1:0] dir_waddr;
    logic [DW-1:0]  dir_wdata, dir_rdata;
    logic           ent_we;
    logic [EAW-1:0] ent_waddr, ent_raddr, ent_addr_dir;
    logic [31:0]    ent_wdata, ent_rdata;

    logic           dir_present;
    logic           is_map;
    logic           pool_full;
    logic           alloc;
    logic [TW-1:0]  tnum;
    logic           ent_write;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = ctrl.ready;
    assign o_valid  = r_out_valid;
    assign o_rsp    = r_rsp;

    tlpm_seq #(
        .TABLE_POOL (TABLE_POOL)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_free (out_free),
        .o_ctrl     (ctrl),
        .o_clr_addr (clr_addr)
    );

    // Directory step: look at the slot, allocate a table if needed
    assign is_map      = (r_req.kind == KIND_MAP);
    assign dir_present = dir_rdata[TW];
    assign pool_full   = (r_used == UW'(TABLE_POOL));
    assign alloc       = ctrl.dir_stage && is_map && !dir_present && !pool_full;
    assign tnum        = dir_present ? dir_rdata[TW-1:0] : TW'(r_used);
    assign ent_addr_dir = EAW'({tnum,
                                r_req.virtual_address[PAGE_SHIFT +: IDX_W]});

    // Directory RAM ports
    always_comb begin
        dir_we    = 1'b0;
        dir_waddr = r_req.virtual_address[DIR_SHIFT +: IDX_W];
        dir_wdata = {1'b1, TW'(r_used)};
        if (ctrl.clearing) begin
            dir_we    = ctrl.clr_dir;
            dir_waddr = clr_addr[IDX_W-1:0];
            dir_wdata = '0;
        end else if (alloc) begin
            dir_we    = 1'b1;
        end
    end

    tlpm_ram #(
        .WIDTH (DW),
        .DEPTH (DIR_SLOTS)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (dir_wdata),
        .i_raddr (i_req.virtual_address[DIR_SHIFT +: IDX_W]),
        .o_rdata (dir_rdata)
    );

    // Entry RAM ports; present flag is bit 0 of the stored word
    assign ent_raddr = ctrl.dir_stage ? ent_addr_dir : r_ent_addr;
    assign ent_write = ctrl.finish && is_map && !r_no_table && !ent_rdata[0];

    always_comb begin
        ent_we    = ent_write;
        ent_waddr = r_ent_addr;
        ent_wdata = r_req.physical_address | {24'd0, r_req.flags} | PRESENT_BIT;
        if (ctrl.clearing) begin
            ent_we    = 1'b1;
            ent_waddr = clr_addr;
            ent_wdata = '0;
        end
    end

    tlpm_ram #(
        .WIDTH (32),
        .DEPTH (ENT_DEPTH)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    // Result formation
    always_comb begin
        n_rsp = '{translated_address: 32'd0, status: STAT_OK};
        if (!is_map) begin
            if (!r_dir_hit) begin
                n_rsp.status = STAT_DIR_ABSENT;
            end else if (!ent_rdata[0]) begin
                n_rsp.status = STAT_PG_ABSENT;
            end else begin
                n_rsp.translated_address = {ent_rdata[31:OFFSET_W],
                                            r_req.virtual_address[OFFSET_W-1:0]};
            end
        end else begin
            if (r_no_table) begin
                n_rsp.status = STAT_NO_TABLE;
            end else if (ent_rdata[0]) begin
                n_rsp.status = STAT_ALREADY;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && ctrl.ready) begin
            r_req <= i_req;
        end
        if (ctrl.dir_stage) begin
            r_ent_addr <= ent_addr_dir;
            r_dir_hit  <= dir_present;
            r_no_table <= is_map && !dir_present && pool_full;
        end
        if (ctrl.finish) begin
            r_rsp <= n_rsp;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (alloc) begin
                r_used <= r_used + UW'(1);
            end
            if (ctrl.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Checks
    a_accept_to_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> ctrl.dir_stage)
        else $error("accepted request did not enter the directory step");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.finish |=> o_valid)
        else $error("finished request left no result");

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(TABLE_POOL))
        else $error("table pool count overflow");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != STAT_OK) |-> o_rsp.translated_address == 32'd0)
        else $error("failed request carries an address");

endmodule

`default_nettype wire

/* src/tlpm_ram.sv */
// ----------------------------------------------------------------------------
// tlpm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* src/tlpm_seq.sv */
// ----------------------------------------------------------------------------
// tlpm_seq
// Request sequencer: post-reset clearing sweep, then the directory and
// entry read steps of each request.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpm_seq #(
    parameter int TABLE_POOL = 16,
    localparam int EAW = $clog2(TABLE_POOL * tlpm_pkg::TABLE_ENTRIES)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic                 i_out_free,
    output tlpm_pkg::t_seq_ctrl       o_ctrl,
    output logic          [EAW-1:0]   o_clr_addr
);
    import tlpm_pkg::*;

    localparam int ENT_DEPTH = TABLE_POOL * TABLE_ENTRIES;

    t_state         r_state, n_state;
    logic [EAW-1:0] r_clr, n_clr;
    logic           clr_last;

    assign clr_last   = (r_clr == EAW'(ENT_DEPTH - 1));
    assign o_clr_addr = r_clr;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_valid) n_state = S_DIR;
            S_DIR:   n_state = S_ENT;
            S_ENT: begin
                if (i_out_free) begin
                    n_state = i_valid ? S_DIR : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sweep counter
    always_comb begin
        n_clr = r_clr;
        if (r_state == S_CLEAR && !clr_last) begin
            n_clr = r_clr + EAW'(1);
        end
    end

    // Outputs
    always_comb begin
        o_ctrl           = '0;
        o_ctrl.clr_dir   = ({1'b0, r_clr} < (EAW + 1)'(DIR_SLOTS));
        case (r_state)
            S_CLEAR: o_ctrl.clearing = 1'b1;
            S_IDLE:  o_ctrl.ready = 1'b1;
            S_DIR:   o_ctrl.dir_stage = 1'b1;
            S_ENT: begin
                o_ctrl.ready  = i_out_free;
                o_ctrl.finish = i_out_free;
            end
            default: o_ctrl.ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-level page map translator. A queue of
// translate and map requests is built up front. The driver issues them in
// bursts. The monitor drains responses under a shifting stall pattern and
// checks every field against a shadow copy of the directory and the page
// tables.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tlpm_pkg::*;

    localparam int POOL       = 16;
    localparam int ENTRIES    = POOL * TABLE_ENTRIES;
    localparam int RAND_REQS  = 1525;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_ready = 1'b0;
    t_req  i_req   = '0;
    logic  o_ready;
    logic  o_valid;
    t_rsp  o_rsp;

    two_level_page_map_translate #(
        .TABLE_POOL(POOL)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    // Shadow page map
    logic        dir_valid [DIR_SLOTS];
    logic [3:0]  dir_table [DIR_SLOTS];
    int          tables_used;
    logic        pte_valid [ENTRIES];
    logic [31:0] pte_word  [ENTRIES];

    t_req        page_reqs[$];
    t_rsp        expected_lookups[$];
    logic [31:0] mapped_vas[$];
    logic [9:0]  home_dirs [16];

    int          error_count   = 0;
    int          reqs_accepted = 0;
    int          rsps_checked  = 0;
    int          status_seen [5];

    // Sender burst/gap bookkeeping
    int          burst_left = 1;
    int          gap_left   = 0;

    // Receiver stall pattern
    int          rdy_mode = 0;
    int          rdy_left = 0;
    logic [7:0]  cyc      = '0;

    // Walk the shadow map for one request, updating it on a map
    function automatic t_rsp walk_page_map(t_req rq);
        logic [9:0]  dir_idx;
        logic [9:0]  pg_idx;
        logic [13:0] pos;
        t_rsp        r;
        dir_idx = rq.virtual_address[31:22];
        pg_idx  = rq.virtual_address[21:12];
        r.translated_address = '0;
        r.status = STAT_OK;
        if (rq.kind == KIND_TRANSLATE) begin
            if (!dir_valid[dir_idx]) begin
                r.status = STAT_DIR_ABSENT;
            end else begin
                pos = {dir_table[dir_idx], pg_idx};
                if (!pte_valid[pos]) begin
                    r.status = STAT_PG_ABSENT;
                end else begin
                    r.translated_address = {pte_word[pos][31:12],
                                            rq.virtual_address[11:0]};
                end
            end
        end else begin
            if (!dir_valid[dir_idx] && tables_used >= POOL) begin
                r.status = STAT_NO_TABLE;
            end else begin
                // empty slot takes the next pool table
                if (!dir_valid[dir_idx]) begin
                    dir_valid[dir_idx] = 1'b1;
                    dir_table[dir_idx] = 4'(tables_used);
                    tables_used++;
                end
                pos = {dir_table[dir_idx], pg_idx};
                if (pte_valid[pos]) begin
                    r.status = STAT_ALREADY;
                end else begin
                    pte_valid[pos] = 1'b1;
                    pte_word[pos]  = rq.physical_address | {24'd0, rq.flags} | PRESENT_BIT;
                end
            end
        end
        return r;
    endfunction

    function automatic void queue_req(logic kind, logic [31:0] va, logic [31:0] pa,
                                      logic [7:0] fl);
        t_req rq;
        rq.kind             = kind;
        rq.virtual_address  = va;
        rq.physical_address = pa;
        rq.flags            = fl;
        page_reqs.push_back(rq);
    endfunction

    // Clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Driver: bursts of requests separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_lookups.push_back(walk_page_map(i_req));
                reqs_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (page_reqs.size() != 0) begin
                    i_req   <= page_reqs.pop_front();
                    i_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        // a quarter of bursts run straight into the next
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall mode is redrawn whenever its run counter expires
    always @(posedge i_clk) begin
        cyc <= cyc + 8'd1;
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = $urandom_range(32, 200);
        end else begin
            rdy_left--;
        end
        case (rdy_mode)
            0: begin
                i_ready <= 1'b1;
            end
            1: begin
                i_ready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                i_ready <= cyc[2] ^ cyc[0];
            end
            default: begin
                i_ready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    // Monitor: compare each response with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_lookups.size() == 0) begin
                $error("unexpected response: translated_address %h status %0d",
                       o_rsp.translated_address, o_rsp.status);
                error_count++;
            end else begin
                t_rsp exp_rsp;
                exp_rsp = expected_lookups.pop_front();
                if (o_rsp.translated_address !== exp_rsp.translated_address) begin
                    $error("translated_address: expected %h, actual %h",
                           exp_rsp.translated_address, o_rsp.translated_address);
                    error_count++;
                end
                if (o_rsp.status !== exp_rsp.status) begin
                    $error("status: expected %0d, actual %0d",
                           exp_rsp.status, o_rsp.status);
                    error_count++;
                end
                if (exp_rsp.status <= STAT_NO_TABLE) begin
                    status_seen[exp_rsp.status]++;
                end
                rsps_checked++;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int          pick;
        int          total_reqs;
        logic [9:0]  d;
        logic [31:0] va;
        logic [31:0] old_va;

        for (int i = 0; i < DIR_SLOTS; i++) begin
            dir_valid[i] = 1'b0;
            dir_table[i] = '0;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            pte_valid[i] = 1'b0;
            pte_word[i]  = '0;
        end
        for (int i = 0; i < 5; i++) status_seen[i] = 0;
        tables_used = 0;

        // Sixteen slots that will own the whole pool; every index bit toggles
        home_dirs = '{10'h000, 10'h3FF, 10'h001, 10'h002, 10'h004, 10'h008,
                      10'h010, 10'h020, 10'h040, 10'h080, 10'h100, 10'h200,
                      10'h155, 10'h2AA, 10'h3FE, 10'h1FF};

        // Directed: empty map, extremes, repeat map, missing page
        queue_req(KIND_TRANSLATE, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF);
        queue_req(KIND_TRANSLATE, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00);
        queue_req(KIND_MAP,       32'h0000_0000, 32'hFFFF_FFFF, 8'hFF);
        queue_req(KIND_TRANSLATE, 32'h0000_0FFF, 32'h0000_0000, 8'h00);
        queue_req(KIND_MAP,       32'h0000_0000, 32'h1234_5000, 8'h02);
        queue_req(KIND_TRANSLATE, 32'h0000_1000, 32'h0000_0000, 8'h00);
        queue_req(KIND_MAP,       32'hFFFF_FFFF, 32'h0000_0000, 8'h00);
        queue_req(KIND_TRANSLATE, 32'hFFFF_F000, 32'hFFFF_FFFF, 8'hFF);
        // low bits of the physical address are kept but hidden on translate
        queue_req(KIND_MAP,       32'h003F_F000, 32'h1234_5ABC, 8'h80);
        queue_req(KIND_TRANSLATE, 32'h003F_F123, 32'h0000_0000, 8'h00);
        mapped_vas.push_back(32'h0000_0000);
        mapped_vas.push_back(32'hFFFF_F000);
        mapped_vas.push_back(32'h003F_F000);

        // use up the rest of the pool
        for (int i = 2; i < 16; i++) begin
            va = {home_dirs[i], 10'($urandom_range(0, 1023)), 12'($urandom)};
            queue_req(KIND_MAP, va, $urandom, 8'($urandom));
            mapped_vas.push_back(va);
        end
        // pool exhausted: new slot refused and still absent
        queue_req(KIND_MAP,       32'hC000_0000, 32'hABCD_E000, 8'h55);
        queue_req(KIND_TRANSLATE, 32'hC000_0000, 32'h0000_0000, 8'h00);
        queue_req(KIND_MAP,       32'h0000_2000, 32'h0BAD_F000, 8'hAA);
        queue_req(KIND_TRANSLATE, 32'h0000_2ABC, 32'h0000_0000, 8'h00);
        mapped_vas.push_back(32'h0000_2000);

        // Random: mostly walks through the owned slots, some noise
        for (int n = 0; n < RAND_REQS; n++) begin
            pick = $urandom_range(0, 99);
            d    = home_dirs[$urandom_range(0, 15)];
            va   = {d, 10'($urandom_range(0, 1023)), 12'($urandom)};
            if (pick < 35) begin
                queue_req(KIND_MAP, va, $urandom, 8'($urandom));
                mapped_vas.push_back(va);
            end else if (pick < 70 && mapped_vas.size() != 0) begin
                old_va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
                queue_req(KIND_TRANSLATE, {old_va[31:12], 12'($urandom)},
                          $urandom, 8'($urandom));
            end else if (pick < 85) begin
                queue_req(KIND_TRANSLATE, va, $urandom, 8'($urandom));
            end else if (pick < 90 && mapped_vas.size() != 0) begin
                old_va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
                queue_req(KIND_MAP, old_va, $urandom, 8'($urandom));
            end else begin
                queue_req(1'($urandom), $urandom, $urandom, 8'($urandom));
            end
        end
        total_reqs = page_reqs.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every queued request to be answered, then keep running
        // so that any stray response is caught
        while (rsps_checked < total_reqs) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("Checked %0d of %0d requests: ok %0d, dir absent %0d, page absent %0d,",
                 rsps_checked, reqs_accepted, status_seen[0], status_seen[1],
                 status_seen[2]);
        $display("already mapped %0d, no free table %0d; %0d of %0d pool tables taken",
                 status_seen[3], status_seen[4], tables_used, POOL);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: clearing sweep plus the whole run several times over
    initial begin
        #6ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
